[src/osr_pkg.sv]
// Shared types, constants and register codes for the oblique slice resampler.
package osr_pkg;

	localparam int DEF_VOL_WIDTH  = 32;
	localparam int DEF_VOL_HEIGHT = 32;
	localparam int DEF_VOL_DEPTH  = 32;

	localparam int MEM_WORDS  = 32768;
	localparam int ADDR_W     = 15;
	localparam int VOXEL_W    = 16;
	localparam int COORD_W    = 20;
	localparam int CORNER_W   = 3 * COORD_W;
	localparam int RC_W       = 5;
	localparam int IDX_W      = 9;
	localparam int WEIGHT_W   = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int SCALE_MAX  = 255;

	localparam logic [CFG_IDX_W-1:0] CFG_CORNER_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CORNER_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CORNER_C = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CORNER_D = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_LOW  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_HIGH = 3'd5;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef struct packed {
		logic                     op;
		logic [ADDR_W-1:0]        voxel_addr;
		logic signed [VOXEL_W-1:0] voxel_value;
		logic [RC_W-1:0]          row;
		logic [RC_W-1:0]          col;
	} item_t;

	typedef struct packed {
		logic [7:0] pixel;
		logic       outside;
	} result_t;

endpackage

[src/osr_axis.sv]
// One coordinate axis: weighted corner sum, box test and index division.
module osr_axis #(
	parameter int VOL_WIDTH  = osr_pkg::DEF_VOL_WIDTH,
	parameter int VOL_HEIGHT = osr_pkg::DEF_VOL_HEIGHT,
	parameter int SIZE       = osr_pkg::DEF_VOL_WIDTH
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [osr_pkg::COORD_W-1:0]     ca,
	input  logic signed [osr_pkg::COORD_W-1:0]     cb,
	input  logic signed [osr_pkg::COORD_W-1:0]     cc,
	input  logic signed [osr_pkg::COORD_W-1:0]     cd,
	input  logic signed [osr_pkg::WEIGHT_W-1:0]    w_ad,
	input  logic signed [osr_pkg::WEIGHT_W-1:0]    w_d,
	input  logic signed [osr_pkg::WEIGHT_W-1:0]    w_b,
	input  logic signed [osr_pkg::WEIGHT_W-1:0]    w_c,
	output logic [osr_pkg::IDX_W-1:0]              idx,
	output logic                                   outside
);
	import osr_pkg::*;

	localparam int  PW  = COORD_W + WEIGHT_W;
	localparam int  SW  = PW + 2;
	localparam int  RW  = 26;
	localparam longint M   = longint'(VOL_HEIGHT - 1) * longint'(VOL_WIDTH - 1);
	localparam longint LIM = longint'(SIZE) * M * 256;

	logic signed [PW-1:0] p_s3 [4];
	logic signed [SW-1:0] num_c;
	logic [RW-1:0]        rem_s4, rem_s5;
	logic                 out_s4, out_s5, out_s6;
	logic [IDX_W-1:0]     q_s5, idx_s6;
	logic [RW-1:0]        rem_a, rem_b;
	logic [IDX_W-1:0]     q_a, q_b;

	// Multiply each corner by its bilinear weight
	always_ff @(posedge clk) begin
		if (en) begin
			p_s3[0] <= ca * w_ad;
			p_s3[1] <= cd * w_d;
			p_s3[2] <= cb * w_b;
			p_s3[3] <= cc * w_c;
		end
	end

	assign num_c = SW'(p_s3[0]) + SW'(p_s3[1]) + SW'(p_s3[2]) + SW'(p_s3[3]);

	// Sum, test against the box and drop the fraction bits
	always_ff @(posedge clk) begin
		if (en) begin
			out_s4 <= (num_c < 0) || (num_c > $signed(SW'(LIM)));
			rem_s4 <= num_c[RW+7:8];
		end
	end

	// Upper quotient digits
	always_comb begin
		rem_a = rem_s4;
		q_a   = '0;
		for (int k = IDX_W - 1; k >= 5; k--) begin
			if (rem_a >= (RW'(M) << k)) begin
				rem_a = rem_a - (RW'(M) << k);
				q_a[k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s5 <= rem_a;
			q_s5   <= q_a;
			out_s5 <= out_s4;
		end
	end

	// Lower quotient digits
	always_comb begin
		rem_b = rem_s5;
		q_b   = q_s5;
		for (int k = 4; k >= 0; k--) begin
			if (rem_b >= (RW'(M) << k)) begin
				rem_b = rem_b - (RW'(M) << k);
				q_b[k] = 1'b1;
			end
		end
	end

	// Pull a point on the far face back onto the last voxel
	always_ff @(posedge clk) begin
		if (en) begin
			out_s6 <= out_s5;
			if (q_b == IDX_W'(SIZE))
				idx_s6 <= IDX_W'(SIZE - 1);
			else
				idx_s6 <= q_b;
		end
	end

	assign idx     = idx_s6;
	assign outside = out_s6;

endmodule

[src/osr_scale.sv]
// Window clamp and byte scaling with a two-stage restoring divider.
module osr_scale (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [osr_pkg::VOXEL_W-1:0]    voxel,
	input  logic                                  outside,
	input  logic signed [osr_pkg::VOXEL_W-1:0]    win_low,
	input  logic signed [osr_pkg::VOXEL_W-1:0]    win_high,
	output osr_pkg::result_t                      result
);
	import osr_pkg::*;

	localparam int DW = VOXEL_W + 1;
	localparam int NW = 25;

	logic signed [VOXEL_W-1:0] vv;
	logic signed [DW-1:0]      diff;
	logic [NW-1:0]             numer_s9, rem_s10, rem_a, rem_b;
	logic [DW-1:0]             div_s9, div_s10;
	logic                      empty_s9, empty_s10, out_s9, out_s10;
	logic [7:0]                q_s10, q_a, q_b;
	result_t                   res_s11;

	// Clamp into the window and form the scaled numerator
	always_comb begin
		vv = outside ? '0 : voxel;
		if (vv < win_low)
			vv = win_low;
		if (vv > win_high)
			vv = win_high;
		diff = DW'(vv) - DW'(win_low);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numer_s9 <= NW'(diff[DW-1:0]) * NW'(SCALE_MAX);
			div_s9   <= DW'(DW'(win_high) - DW'(win_low));
			empty_s9 <= (win_high <= win_low);
			out_s9   <= outside;
		end
	end

	// Upper quotient bits
	always_comb begin
		rem_a = numer_s9;
		q_a   = '0;
		for (int k = 7; k >= 4; k--) begin
			if (rem_a >= (NW'(div_s9) << k)) begin
				rem_a = rem_a - (NW'(div_s9) << k);
				q_a[k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s10   <= rem_a;
			q_s10     <= q_a;
			div_s10   <= div_s9;
			empty_s10 <= empty_s9;
			out_s10   <= out_s9;
		end
	end

	// Lower quotient bits
	always_comb begin
		rem_b = rem_s10;
		q_b   = q_s10;
		for (int k = 3; k >= 0; k--) begin
			if (rem_b >= (NW'(div_s10) << k)) begin
				rem_b = rem_b - (NW'(div_s10) << k);
				q_b[k] = 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (en) begin
			res_s11.pixel   <= empty_s10 ? 8'd0 : q_b;
			res_s11.outside <= out_s10;
		end
	end

	assign result = res_s11;

endmodule

[src/oblique_slice_resampler_core.sv]
// Each sample transfer gives one result, in order; loads give no result.
// Throughput: one item per cycle while the result is not stalled; the single volume read port sets that figure.
// A stalled result holds the whole pipeline in place until it is taken.
// Reset clears valid bits and configuration (window 0..255, corners 0);
// the volume memory is not cleared and must be loaded before sampling.
module oblique_slice_resampler_core #(
	parameter int VOL_WIDTH  = osr_pkg::DEF_VOL_WIDTH,
	parameter int VOL_HEIGHT = osr_pkg::DEF_VOL_HEIGHT,
	parameter int VOL_DEPTH  = osr_pkg::DEF_VOL_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  osr_pkg::item_t                    item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output osr_pkg::result_t                  result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [osr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [osr_pkg::CORNER_W-1:0]      cfg_data
);
	import osr_pkg::*;

	localparam int NSTG   = 11;
	localparam int AW     = ADDR_W + 10;
	localparam int LD_DLY = 6;

	logic [CORNER_W-1:0]       corner_q [4];
	logic signed [VOXEL_W-1:0] win_low_q, win_high_q;
	logic [NSTG-1:0]           vld_q;
	logic                      en;
	item_t                     item_s1;
	logic                      load_s1;
	logic [LD_DLY-1:0]         ld_vld_q;
	logic [ADDR_W-1:0]         ld_addr_q [LD_DLY];
	logic [VOXEL_W-1:0]        ld_data_q [LD_DLY];
	logic signed [9:0]         wr, wc, rr, cc;
	logic signed [WEIGHT_W-1:0] w_s2 [4];
	logic [IDX_W-1:0]          idx [3];
	logic                      out_ax [3];
	logic [ADDR_W-1:0]         addr_s7;
	logic                      out_s7, out_s8;
	logic signed [VOXEL_W-1:0] rd_s8;
	logic [VOXEL_W-1:0]        mem [0:MEM_WORDS-1];

	assign en           = !(vld_q[NSTG-1] && result_stall);
	assign item_stall   = !en;
	assign result_valid = vld_q[NSTG-1];
	assign cfg_ready    = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				corner_q[i] <= '0;
			win_low_q  <= '0;
			win_high_q <= 16'sd255;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CORNER_A: corner_q[0] <= cfg_data;
				CFG_CORNER_B: corner_q[1] <= cfg_data;
				CFG_CORNER_C: corner_q[2] <= cfg_data;
				CFG_CORNER_D: corner_q[3] <= cfg_data;
				CFG_WIN_LOW:  win_low_q   <= cfg_data[VOXEL_W-1:0];
				CFG_WIN_HIGH: win_high_q  <= cfg_data[VOXEL_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance the valid bits of sample and load transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			load_s1  <= 1'b0;
			ld_vld_q <= '0;
		end else if (en) begin
			vld_q    <= {vld_q[NSTG-2:0], item_valid && (item.op == OP_SAMPLE)};
			load_s1  <= item_valid && (item.op == OP_LOAD);
			ld_vld_q <= {ld_vld_q[LD_DLY-2:0], load_s1};
		end
	end

	// Capture the incoming item
	always_ff @(posedge clk) begin
		if (en)
			item_s1 <= item;
	end

	// Delay loads to the read stage so the volume sees items in order
	always_ff @(posedge clk) begin
		if (en) begin
			ld_addr_q[0] <= item_s1.voxel_addr;
			ld_data_q[0] <= item_s1.voxel_value;
			for (int i = 1; i < LD_DLY; i++) begin
				ld_addr_q[i] <= ld_addr_q[i-1];
				ld_data_q[i] <= ld_data_q[i-1];
			end
		end
	end

	// Bilinear weights from row and column
	assign rr = $signed({5'b0, item_s1.row});
	assign cc = $signed({5'b0, item_s1.col});
	assign wr = $signed(10'(VOL_HEIGHT - 1)) - rr;
	assign wc = $signed(10'(VOL_WIDTH - 1)) - cc;

	always_ff @(posedge clk) begin
		if (en) begin
			w_s2[0] <= wr * wc;
			w_s2[1] <= rr * wc;
			w_s2[2] <= wr * cc;
			w_s2[3] <= rr * cc;
		end
	end

	// Per-axis coordinate units
	for (genvar a = 0; a < 3; a++) begin : g_axis
		localparam int SZ = (a == 0) ? VOL_WIDTH : ((a == 1) ? VOL_HEIGHT : VOL_DEPTH);
		osr_axis #(
			.VOL_WIDTH  (VOL_WIDTH),
			.VOL_HEIGHT (VOL_HEIGHT),
			.SIZE       (SZ)
		) u_axis (
			.clk     (clk),
			.en      (en),
			.ca      (corner_q[0][COORD_W*a +: COORD_W]),
			.cb      (corner_q[1][COORD_W*a +: COORD_W]),
			.cc      (corner_q[2][COORD_W*a +: COORD_W]),
			.cd      (corner_q[3][COORD_W*a +: COORD_W]),
			.w_ad    (w_s2[0]),
			.w_d     (w_s2[1]),
			.w_b     (w_s2[2]),
			.w_c     (w_s2[3]),
			.idx     (idx[a]),
			.outside (out_ax[a])
		);
	end

	// Linear read address, wrapped to the memory size
	always_ff @(posedge clk) begin
		if (en) begin
			addr_s7 <= ADDR_W'(AW'(idx[2]) * AW'(VOL_HEIGHT * VOL_WIDTH)
				+ AW'(idx[1]) * AW'(VOL_WIDTH) + AW'(idx[0]));
			out_s7  <= out_ax[0] || out_ax[1] || out_ax[2];
		end
	end

	// Volume memory: load writes and sample reads at the same stage
	always_ff @(posedge clk) begin
		if (en && ld_vld_q[LD_DLY-1])
			mem[ld_addr_q[LD_DLY-1]] <= ld_data_q[LD_DLY-1];
		if (en)
			rd_s8 <= mem[addr_s7];
	end

	always_ff @(posedge clk) begin
		if (en)
			out_s8 <= out_s7;
	end

	osr_scale u_scale (
		.clk      (clk),
		.en       (en),
		.voxel    (rd_s8),
		.outside  (out_s8),
		.win_low  (win_low_q),
		.win_high (win_high_q),
		.result   (result)
	);

	a_stall_match: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall == (result_valid && result_stall))
		else $error("input stall does not follow output back-pressure");

	a_sample_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && item.op == OP_SAMPLE) |=> vld_q[0])
		else $error("accepted sample missing from first stage");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> $stable(vld_q))
		else $error("pipeline moved while output stalled");

endmodule

[test/oblique_slice_resampler_core_tb.sv]
// Self-checking testbench for the oblique slice resampler core.
`timescale 1ns / 100ps

module oblique_slice_resampler_core_tb;
	import osr_pkg::*;

	localparam int VW = DEF_VOL_WIDTH;
	localparam int VH = DEF_VOL_HEIGHT;
	localparam int VD = DEF_VOL_DEPTH;
	localparam int FACE = 256 * VW;  // far face of the box in Q12.8
	localparam int DRAIN_CYCLES = 20;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CORNER_W-1:0] cfg_data;

	// predictor state
	logic signed [VOXEL_W-1:0] vol_mem [0:MEM_WORDS-1];
	bit vol_written [0:MEM_WORDS-1];
	logic [CORNER_W-1:0] corner_q [0:3];
	int win_lo;
	int win_hi;
	result_t pixel_q [$];

	int err_count;
	int n_loads;
	int n_samples;
	int n_outside;
	int n_cfg;
	int burst_left;
	int stall_pct;
	int stall_tick;

	oblique_slice_resampler_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock and simulation timeout
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("oblique_slice_resampler_core_tb: errors");
		$finish;
	end

	// receiver stall pattern, stall density redrawn from 0, 20, 50 or 85 percent
	always @(negedge clk) begin
		stall_tick++;
		if (stall_tick % 50 == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 50;
				default: stall_pct = 85;
			endcase
		end
		result_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		err_count++;
	endtask

	// check each result transfer against the oldest expected pixel
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pixel_q.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = pixel_q.pop_front();
				if (result.pixel !== want.pixel)
					report_mismatch("pixel", result.pixel, want.pixel);
				if (result.outside !== want.outside)
					report_mismatch("outside", result.outside, want.outside);
			end
		end
	end

	function automatic logic [CORNER_W-1:0] pack_point(input int x, input int y, input int z);
		logic [COORD_W-1:0] bx, by, bz;
		bx = x[COORD_W-1:0];
		by = y[COORD_W-1:0];
		bz = z[COORD_W-1:0];
		return {bz, by, bx};
	endfunction

	// map a pixel position onto the slice; returns 1 when outside the box
	function automatic bit locate(input logic [RC_W-1:0] r, input logic [RC_W-1:0] c,
			output int addr);
		longint num, den, sz, wr, wc, rr, cc;
		longint idx [3];
		longint p [4];
		bit outs;
		outs = 1'b0;
		addr = 0;
		rr = r;
		cc = c;
		wr = VH - 1 - rr;
		wc = VW - 1 - cc;
		den = longint'(VH - 1) * longint'(VW - 1) * 256;
		for (int a = 0; a < 3; a++) begin
			for (int k = 0; k < 4; k++)
				p[k] = longint'($signed(corner_q[k][a*COORD_W +: COORD_W]));
			sz = (a == 0) ? VW : (a == 1) ? VH : VD;
			num = p[0] * wr * wc + p[3] * rr * wc + p[1] * wr * cc + p[2] * rr * cc;
			if (num < 0 || num > sz * den) begin
				outs = 1'b1;
				idx[a] = 0;
			end else begin
				idx[a] = num / den;
				if (idx[a] == sz)
					idx[a] = sz - 1;
			end
		end
		if (!outs)
			addr = int'((idx[2] * VH * VW + idx[1] * VW + idx[0]) % MEM_WORDS);
		return outs;
	endfunction

	// window and scale the voxel found at a pixel position
	function automatic result_t resample_pixel(input logic [RC_W-1:0] r, input logic [RC_W-1:0] c);
		result_t res;
		int addr;
		bit outs;
		int v;
		v = 0;
		outs = locate(r, c, addr);
		if (!outs)
			v = vol_mem[addr];
		res.pixel = 8'd0;
		if (win_hi > win_lo) begin
			if (v < win_lo) v = win_lo;
			if (v > win_hi) v = win_hi;
			res.pixel = 8'((v - win_lo) * SCALE_MAX / (win_hi - win_lo));
		end
		res.outside = outs;
		return res;
	endfunction

	// send one item; returns at a falling edge after the transfer
	task automatic send_item(input item_t it);
		result_t res;
		item <= it;
		item_valid <= 1'b1;
		forever begin
			@(posedge clk);
			if (!item_stall) break;
		end
		if (it.op == OP_LOAD) begin
			vol_mem[it.voxel_addr] = it.voxel_value;
			vol_written[it.voxel_addr] = 1'b1;
			n_loads++;
		end else begin
			res = resample_pixel(it.row, it.col);
			pixel_q.push_back(res);
			n_samples++;
			if (res.outside) n_outside++;
		end
		@(negedge clk);
		if (burst_left == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(0, 20);
		end else begin
			burst_left--;
		end
	endtask

	task automatic load_voxel(input int addr, input int value);
		item_t it;
		it.op = OP_LOAD;
		it.voxel_addr = addr[ADDR_W-1:0];
		it.voxel_value = value[VOXEL_W-1:0];
		it.row = RC_W'($urandom);
		it.col = RC_W'($urandom);
		send_item(it);
	endtask

	task automatic sample_pixel(input int r, input int c);
		item_t it;
		int addr;
		it.op = OP_SAMPLE;
		it.voxel_addr = ADDR_W'($urandom);
		it.voxel_value = VOXEL_W'($urandom);
		it.row = r[RC_W-1:0];
		it.col = c[RC_W-1:0];
		// load the voxel this sample reads when it has never been written
		if (!locate(it.row, it.col, addr) && !vol_written[addr])
			load_voxel(addr, $urandom_range(0, 65535) - 32768);
		send_item(it);
	endtask

	// lower valid and wait until every expected pixel has come back
	task automatic drain_results();
		item_valid <= 1'b0;
		while (pixel_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CORNER_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		if (idx <= CFG_CORNER_D)
			corner_q[idx] = data;
		else if (idx == CFG_WIN_LOW)
			win_lo = int'($signed(data[VOXEL_W-1:0]));
		else
			win_hi = int'($signed(data[VOXEL_W-1:0]));
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_window(input int lo, input int hi);
		write_reg(CFG_WIN_LOW, CORNER_W'(lo[VOXEL_W-1:0]));
		write_reg(CFG_WIN_HIGH, CORNER_W'(hi[VOXEL_W-1:0]));
	endtask

	task automatic set_corners(input logic [CORNER_W-1:0] a, input logic [CORNER_W-1:0] b,
			input logic [CORNER_W-1:0] c, input logic [CORNER_W-1:0] d);
		write_reg(CFG_CORNER_A, a);
		write_reg(CFG_CORNER_B, b);
		write_reg(CFG_CORNER_C, c);
		write_reg(CFG_CORNER_D, d);
	endtask

	// axis-aligned plane across the whole box at height z
	task automatic set_plane(input int z);
		set_corners(pack_point(0, 0, z), pack_point(FACE, 0, z),
			pack_point(FACE, FACE, z), pack_point(0, FACE, z));
	endtask

	function automatic int rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1 << 20) - (1 << 19);
			1: return $urandom_range(0, 800) - 400;
			2: return FACE - 400 + $urandom_range(0, 800);
			default: return $urandom_range(0, FACE);
		endcase
	endfunction

	function automatic logic [CORNER_W-1:0] rand_corner();
		return pack_point(rand_coord(), rand_coord(), rand_coord());
	endfunction

	// seed the volume with the extremes at the two ends and 30 random voxels
	task automatic test_fill_volume();
		load_voxel(0, -32768);
		load_voxel(MEM_WORDS - 1, 32767);
		for (int i = 0; i < 30; i++)
			load_voxel($urandom_range(1, MEM_WORDS - 2), $urandom_range(0, 65535) - 32768);
		drain_results();
	endtask

	// reset configuration: all corners at the origin
	task automatic test_reset_config();
		sample_pixel(0, 0);
		sample_pixel(31, 31);
		drain_results();
	endtask

	// plane on the far z face, hitting the clamp at the size on every axis
	task automatic test_box_faces();
		set_window(-32768, 32767);
		set_plane(FACE);
		sample_pixel(0, 0);
		sample_pixel(31, 31);
		sample_pixel(0, 31);
		sample_pixel(31, 0);
		sample_pixel(16, 15);
		drain_results();
	endtask

	// points just outside the box and at the coordinate extremes
	task automatic test_outside();
		set_plane(-1);
		sample_pixel(7, 9);
		drain_results();
		set_corners(pack_point(-524288, -524288, -524288), pack_point(524287, -524288, 0),
			pack_point(524287, 524287, 524287), pack_point(0, 524287, 524287));
		sample_pixel(0, 0);
		sample_pixel(31, 31);
		sample_pixel(15, 15);
		sample_pixel(31, 0);
		drain_results();
	endtask

	// empty, inverted and narrow windows
	task automatic test_window_edges();
		set_plane(FACE / 2);
		set_window(100, 100);
		sample_pixel(3, 4);
		drain_results();
		set_window(32767, -32768);
		sample_pixel(20, 5);
		drain_results();
		set_window(-5, 5);
		sample_pixel(10, 10);
		sample_pixel(11, 30);
		drain_results();
		set_window(0, 1);
		sample_pixel(1, 2);
		drain_results();
	endtask

	// random phases of loads and samples under changing settings
	task automatic test_random();
		int lo, hi;
		for (int ph = 0; ph < 6; ph++) begin
			if ($urandom_range(0, 2) == 0)
				set_plane($urandom_range(0, FACE));
			else
				set_corners(rand_corner(), rand_corner(), rand_corner(), rand_corner());
			case ($urandom_range(0, 3))
				0: begin lo = -32768; hi = 32767; end
				1: begin lo = $urandom_range(0, 65535) - 32768; hi = lo; end
				default: begin
					lo = $urandom_range(0, 65535) - 32768;
					hi = $urandom_range(0, 65535) - 32768;
				end
			endcase
			set_window(lo, hi);
			for (int i = 0; i < 40; i++) begin
				if ($urandom_range(0, 99) < 30)
					load_voxel($urandom_range(0, MEM_WORDS - 1),
						$urandom_range(0, 65535) - 32768);
				else
					sample_pixel($urandom_range(0, 31), $urandom_range(0, 31));
				// hold off once mid-phase until all pixels are back
				if (ph == 2 && i == 20) begin
					item_valid <= 1'b0;
					while (pixel_q.size() != 0) @(negedge clk);
				end
			end
			drain_results();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_CORNER_A;
		cfg_data = '0;
		err_count = 0;
		n_loads = 0;
		n_samples = 0;
		n_outside = 0;
		n_cfg = 0;
		burst_left = 0;
		stall_pct = 0;
		stall_tick = 0;
		for (int k = 0; k < 4; k++) corner_q[k] = '0;
		win_lo = 0;
		win_hi = 255;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_fill_volume();
		test_reset_config();
		test_box_faces();
		test_outside();
		test_window_edges();
		test_random();

		$display("covered %0d voxel loads, %0d pixel samples (%0d outside the box)",
			n_loads, n_samples, n_outside);
		$display("under %0d register writes across plane, oblique and window settings", n_cfg);
		if (err_count == 0)
			$display("oblique_slice_resampler_core_tb: clean");
		else
			$display("oblique_slice_resampler_core_tb: errors");
		$finish;
	end

endmodule
